// ===== rtl/core/dh_pkg.sv =====
// Shared constants, codes and the arctangent table for the daylight hours pipeline.
// Used by dh_sincos and daylight_hours_top; depends on nothing else.
package dh_pkg;

  // CORDIC set-up
  localparam int unsigned CORDIC_STEPS = 30;
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [32:0] Q30_ONE  = 33'sd1073741824;

  // Latitude to binary angle: lt = LAT_STEP*lmag + (LAT_REM*lmag + LAT_RND) / 45
  localparam int unsigned LAT_STEP  = 46603;
  localparam int unsigned LAT_REM   = 17;
  localparam int unsigned LAT_RND   = 22;
  localparam int unsigned RECIP45   = 1491309;   // ceil(2^26 / 45)

  // Day to year phase: ph = PH_STEP*m + (PH_REM*m + PH_RND) / 365
  localparam int unsigned DAY_OFFSET = 10;
  localparam int unsigned YEAR_DAYS  = 365;
  localparam int unsigned PH_STEP    = 11767033;
  localparam int unsigned PH_REM     = 251;
  localparam int unsigned PH_RND     = 182;
  localparam int unsigned RECIP365   = 183860;   // ceil(2^26 / 365)
  localparam int unsigned RECIP_SH   = 26;

  // Declination = round(13 * cos / 50) of a quarter turn
  // n = a*2^17 + b, so n/50 = a*DEC_HI_STEP + (a*DEC_HI_REM + b)/50
  localparam int unsigned DEC_MUL     = 13;
  localparam int unsigned DEC_RND     = 25;
  localparam int unsigned DEC_SPLIT   = 17;
  localparam int unsigned DEC_HI_STEP = 2621;
  localparam int unsigned DEC_HI_REM  = 22;
  localparam int unsigned RECIP50     = 5368710;  // ceil(2^28 / 50)
  localparam int unsigned RECIP50_SH  = 28;
  localparam int unsigned DEC_STAGES  = 4;

  // Result scaling
  localparam int unsigned NORM_STEPS = 6;
  localparam int unsigned NORM_TOP   = 60;
  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [14:0] HOURS_FULL = 15'd24576;
  localparam logic [14:0] HOURS_HALF = 15'd12288;
  localparam logic [14:0] HOURS_NONE = 15'd0;

  // Pipeline bookkeeping
  localparam int unsigned SC_LAT   = CORDIC_STEPS + 2;
  localparam int unsigned LAT_DLY  = SC_LAT + DEC_STAGES;
  localparam int unsigned VD_DLY   = NORM_STEPS + SQRT_STEPS + CORDIC_STEPS + 5;
  localparam int unsigned PIPE_LAT = 3 + 2 * SC_LAT + DEC_STAGES + 3 + NORM_STEPS + 3
                                     + SQRT_STEPS + 1 + CORDIC_STEPS + 2;

  typedef enum logic [1:0] {
    LC_NORMAL = 2'd0,
    LC_DAY    = 2'd1,
    LC_NIGHT  = 2'd2
  } light_case_e;

  typedef struct packed {
    logic        fixed;
    logic [14:0] hours;
    light_case_e lcase;
  } verdict_t;

  function automatic logic [29:0] atn(input int unsigned idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/dh_sincos.sv =====
// Pipelined rotation CORDIC: binary angle in, registered Q30 cosine and sine out.
// Depends on dh_pkg for the step count, gain constant and arctangent table.
module dh_sincos (
  input  logic               clk_i,
  input  logic [31:0]        ang_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int unsigned N = dh_pkg::CORDIC_STEPS;
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  logic signed [32:0] x_q [0:N];
  logic signed [32:0] y_q [0:N];
  logic signed [32:0] z_q [0:N];
  logic [1:0]         quad_q [0:N];
  logic               zero_q [0:N];
  logic signed [32:0] xf, yf, xr, yr;

  always_ff @(posedge clk_i) begin
    x_q[0]    <= dh_pkg::CORDIC_K;
    y_q[0]    <= '0;
    z_q[0]    <= {3'b000, ang_i[29:0]};
    quad_q[0] <= ang_i[31:30];
    zero_q[0] <= (ang_i[29:0] == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      quad_q[i+1] <= quad_q[i];
      zero_q[i+1] <= zero_q[i];
      if (!z_q[i][32]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - 33'(dh_pkg::atn(i));
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + 33'(dh_pkg::atn(i));
      end
    end
  end

  // an exact quadrant boundary skips the rotation
  always_comb begin
    if (zero_q[N]) begin
      xf = dh_pkg::Q30_ONE;
      yf = '0;
    end else begin
      xf = x_q[N];
      yf = y_q[N];
    end
    unique case (quad_q[N])
      QUAD_I:   begin xr = xf;  yr = yf;  end
      QUAD_II:  begin xr = -yf; yr = xf;  end
      QUAD_III: begin xr = -xf; yr = -yf; end
      QUAD_IV:  begin xr = yf;  yr = -xf; end
      default:  begin xr = xf;  yr = yf;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cos_o <= 32'(xr);
    sin_o <= 32'(yr);
  end

endmodule

// ===== rtl/core/daylight_hours_top.sv =====
// Daylight hours from latitude and day of year, fully pipelined.
// Depends on dh_pkg and dh_sincos.
//
// Usage:
//   Drive latitude_i (1/256 degree, signed) and day_of_year_i and raise start for one
//   cycle per item; an item is taken at every clock edge with start high, since busy
//   is held low and one item may enter every cycle.
//   Each result appears on day_hours_o (1/1024 hour) and light_case_o for exactly one
//   cycle with done_o high, in order.
//   The pipeline chain is: year-phase CORDIC (32), divide by 50 (4, split by a
//   constant and reciprocal multiply), latitude and declination CORDICs (32), normalise
//   (6), square root (32, one root bit per stage) and vectoring CORDIC (30), plus glue
//   stages.
//   Throughput is one item per cycle.
//   Reset clears the valid chain only; items in flight are dropped and no strobe
//   follows until new items arrive. The receiver must take each result when done_o is
//   high, as there is no back-pressure.
module daylight_hours_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] latitude_i,
  input  logic [8:0]         day_of_year_i,
  output logic               done_o,
  output logic [14:0]        day_hours_o,
  output logic [1:0]         light_case_o
);

  localparam int unsigned N_ROT   = dh_pkg::CORDIC_STEPS;
  localparam int unsigned N_NORM  = dh_pkg::NORM_STEPS;
  localparam int unsigned N_SQRT  = dh_pkg::SQRT_STEPS;
  localparam int unsigned N_LAT   = dh_pkg::PIPE_LAT;
  localparam int unsigned N_LDLY  = dh_pkg::LAT_DLY;
  localparam int unsigned N_VDLY  = dh_pkg::VD_DLY;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } xside_t;

  logic accept;
  logic [N_LAT-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign done_o = vld_q[N_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N_LAT-2:0], accept};
    end
  end

  // ---------------------------------------------------------------- angles in
  logic [15:0] lmag;
  logic [9:0]  dsum, dmod;
  logic [19:0] lv_q;
  logic [31:0] lp_q, pp_q;
  logic [16:0] pv_q;
  logic        lneg_a_q, lneg_b_q;
  logic [13:0] lq_q;
  logic [7:0]  pq_q;
  logic [31:0] lp_b_q, pp_b_q;
  logic [31:0] lt;
  logic [31:0] lat_ang_q, phase_q;

  assign lmag = latitude_i[15] ? (16'd0 - latitude_i) : latitude_i;
  assign dsum = 10'(day_of_year_i) + 10'(dh_pkg::DAY_OFFSET);
  assign dmod = (dsum >= 10'(dh_pkg::YEAR_DAYS)) ? dsum - 10'(dh_pkg::YEAR_DAYS) : dsum;

  always_ff @(posedge clk_i) begin
    lv_q     <= 20'(lmag) * 20'(dh_pkg::LAT_REM) + 20'(dh_pkg::LAT_RND);
    lp_q     <= 32'(lmag) * 32'(dh_pkg::LAT_STEP);
    pv_q     <= 17'(dmod) * 17'(dh_pkg::PH_REM) + 17'(dh_pkg::PH_RND);
    pp_q     <= 32'(dmod) * 32'(dh_pkg::PH_STEP);
    lneg_a_q <= latitude_i[15];
  end

  // divide the remainders by multiplying with reciprocals
  always_ff @(posedge clk_i) begin
    lq_q     <= 14'((41'(lv_q) * 41'(dh_pkg::RECIP45)) >> dh_pkg::RECIP_SH);
    pq_q     <= 8'((35'(pv_q) * 35'(dh_pkg::RECIP365)) >> dh_pkg::RECIP_SH);
    lp_b_q   <= lp_q;
    pp_b_q   <= pp_q;
    lneg_b_q <= lneg_a_q;
  end

  assign lt = lp_b_q + 32'(lq_q);

  always_ff @(posedge clk_i) begin
    lat_ang_q <= lneg_b_q ? (32'd0 - lt) : lt;
    phase_q   <= pp_b_q + 32'(pq_q);
  end

  // ---------------------------------------------------------------- declination
  logic signed [31:0] cy;
  logic [30:0]        cmag;
  logic [33:0]        dn_q;
  logic [29:0]        dhi_q, dhi_b_q;
  logic [21:0]        dlo_q;
  logic [15:0]        dq_q;
  logic               dpos_a_q, dpos_b_q, dpos_c_q;
  logic [31:0]        dm;
  logic [31:0]        dec_ang_q;
  logic [31:0]        lat_dly_q [0:N_LDLY-1];

  dh_sincos u_sc_year (
    .clk_i (clk_i),
    .ang_i (phase_q),
    .cos_o (cy),
    .sin_o ()
  );

  assign cmag = 31'(cy[31] ? -cy : cy);

  always_ff @(posedge clk_i) begin
    dn_q     <= 34'(cmag) * 34'(dh_pkg::DEC_MUL) + 34'(dh_pkg::DEC_RND);
    dpos_a_q <= !cy[31] && (cy != '0);
  end

  // split off the top bits so that only a short remainder needs the reciprocal
  always_ff @(posedge clk_i) begin
    dhi_q    <= 30'(dn_q[33:dh_pkg::DEC_SPLIT]) * 30'(dh_pkg::DEC_HI_STEP);
    dlo_q    <= 22'(dn_q[33:dh_pkg::DEC_SPLIT]) * 22'(dh_pkg::DEC_HI_REM)
                + 22'(dn_q[dh_pkg::DEC_SPLIT-1:0]);
    dpos_b_q <= dpos_a_q;
  end

  always_ff @(posedge clk_i) begin
    dq_q     <= 16'((45'(dlo_q) * 45'(dh_pkg::RECIP50)) >> dh_pkg::RECIP50_SH);
    dhi_b_q  <= dhi_q;
    dpos_c_q <= dpos_b_q;
  end

  assign dm = 32'(dhi_b_q) + 32'(dq_q);

  always_ff @(posedge clk_i) begin
    dec_ang_q <= dpos_c_q ? (32'd0 - dm) : dm;
  end

  // hold the latitude angle until the declination catches up
  always_ff @(posedge clk_i) begin
    lat_dly_q[0] <= lat_ang_q;
    for (int k = 1; k < N_LDLY; k++) begin
      lat_dly_q[k] <= lat_dly_q[k-1];
    end
  end

  // ---------------------------------------------------------------- products
  logic signed [31:0] cl, sl, cd, sd;
  logic signed [63:0] nf_q, df_q, ng_q, dg_q;

  dh_sincos u_sc_lat (
    .clk_i (clk_i),
    .ang_i (lat_dly_q[N_LDLY-1]),
    .cos_o (cl),
    .sin_o (sl)
  );

  dh_sincos u_sc_dec (
    .clk_i (clk_i),
    .ang_i (dec_ang_q),
    .cos_o (cd),
    .sin_o (sd)
  );

  always_ff @(posedge clk_i) begin
    nf_q <= sl * sd;
    df_q <= cl * cd;
  end

  always_ff @(posedge clk_i) begin
    if (df_q[63]) begin
      ng_q <= -nf_q;
      dg_q <= -df_q;
    end else begin
      ng_q <= nf_q;
      dg_q <= df_q;
    end
  end

  // ---------------------------------------------------------------- classify
  dh_pkg::verdict_t   vh_d, vh_q;
  dh_pkg::verdict_t   vd_q [0:N_VDLY-1];
  logic signed [63:0] neg_dg;
  logic signed [63:0] nx_q [0:N_NORM];
  logic [63:0]        nd_q [0:N_NORM];

  assign neg_dg = -dg_q;

  always_comb begin
    vh_d.fixed = 1'b1;
    vh_d.hours = dh_pkg::HOURS_HALF;
    vh_d.lcase = dh_pkg::LC_NORMAL;
    priority if (dg_q == '0) begin
      // pole: the tangent is saturated, follow the sign of the numerator
      if (ng_q > 64'sd0) begin
        vh_d.hours = dh_pkg::HOURS_FULL;
        vh_d.lcase = dh_pkg::LC_DAY;
      end else if (ng_q < 64'sd0) begin
        vh_d.hours = dh_pkg::HOURS_NONE;
        vh_d.lcase = dh_pkg::LC_NIGHT;
      end
    end else if (ng_q >= dg_q) begin
      vh_d.hours = dh_pkg::HOURS_FULL;
      vh_d.lcase = dh_pkg::LC_DAY;
    end else if (ng_q <= neg_dg) begin
      vh_d.hours = dh_pkg::HOURS_NONE;
      vh_d.lcase = dh_pkg::LC_NIGHT;
    end else begin
      vh_d.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    vh_q    <= vh_d;
    nx_q[0] <= -ng_q;
    nd_q[0] <= dg_q;
  end

  always_ff @(posedge clk_i) begin
    vd_q[0] <= vh_q;
    for (int k = 1; k < N_VDLY; k++) begin
      vd_q[k] <= vd_q[k-1];
    end
  end

  // ---------------------------------------------------------------- normalise
  for (genvar j = 0; j < N_NORM; j++) begin : g_norm
    localparam int unsigned SH = (1 << (N_NORM - 1)) >> j;
    always_ff @(posedge clk_i) begin
      if (nd_q[j][63:dh_pkg::NORM_TOP+1-SH] == '0) begin
        nd_q[j+1] <= nd_q[j] << SH;
        nx_q[j+1] <= nx_q[j] <<< SH;
      end else begin
        nd_q[j+1] <= nd_q[j];
        nx_q[j+1] <= nx_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- y = sqrt(d^2 - x^2)
  logic [63:0] xabs64;
  logic [30:0] xmag;
  xside_t      xi_q, xj_q;
  xside_t      xs_q [0:N_SQRT];
  logic [30:0] di_q;
  logic [61:0] dd_q, xx_q;
  logic [63:0] sv_q [0:N_SQRT];
  logic [63:0] sr_q [0:N_SQRT];

  assign xabs64 = nx_q[N_NORM][63] ? 64'(-nx_q[N_NORM]) : 64'(nx_q[N_NORM]);
  assign xmag   = xabs64[60:30];

  // truncate toward zero: magnitude shifted, sign kept only if non-zero
  always_ff @(posedge clk_i) begin
    di_q     <= nd_q[N_NORM][60:30];
    xi_q.mag <= xmag;
    xi_q.neg <= nx_q[N_NORM][63] && (xmag != '0);
  end

  always_ff @(posedge clk_i) begin
    dd_q <= di_q * di_q;
    xx_q <= xi_q.mag * xi_q.mag;
    xj_q <= xi_q;
  end

  always_ff @(posedge clk_i) begin
    sv_q[0] <= 64'(dd_q - xx_q);
    sr_q[0] <= '0;
    xs_q[0] <= xj_q;
  end

  for (genvar i = 0; i < N_SQRT; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (N_SQRT - 1 - i));
    logic [63:0] trial;
    assign trial = sr_q[i] + BIT;
    always_ff @(posedge clk_i) begin
      xs_q[i+1] <= xs_q[i];
      if (sv_q[i] >= trial) begin
        sv_q[i+1] <= sv_q[i] - trial;
        sr_q[i+1] <= (sr_q[i] >> 1) + BIT;
      end else begin
        sv_q[i+1] <= sv_q[i];
        sr_q[i+1] <= sr_q[i] >> 1;
      end
    end
  end

  // ---------------------------------------------------------------- angle of (x, y)
  logic signed [33:0] vx_q [0:N_ROT];
  logic signed [33:0] vy_q [0:N_ROT];
  logic signed [33:0] vz_q [0:N_ROT];
  logic               vb_q [0:N_ROT];
  logic signed [34:0] zt;
  logic [31:0]        ang_q;
  logic [33:0]        h3;

  // negative x: turn by a quarter first so the rotation starts in the right half
  always_ff @(posedge clk_i) begin
    vz_q[0] <= '0;
    vb_q[0] <= xs_q[N_SQRT].neg;
    if (xs_q[N_SQRT].neg) begin
      vx_q[0] <= 34'(sr_q[N_SQRT][30:0]);
      vy_q[0] <= 34'(xs_q[N_SQRT].mag);
    end else begin
      vx_q[0] <= 34'(xs_q[N_SQRT].mag);
      vy_q[0] <= 34'(sr_q[N_SQRT][30:0]);
    end
  end

  for (genvar i = 0; i < N_ROT; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      vb_q[i+1] <= vb_q[i];
      if (!vy_q[i][33]) begin
        vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] + 34'(dh_pkg::atn(i));
      end else begin
        vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] - 34'(dh_pkg::atn(i));
      end
    end
  end

  assign zt = 35'(vz_q[N_ROT]) + (vb_q[N_ROT] ? 35'sd1073741824 : 35'sd0);

  // clamp to a half turn
  always_ff @(posedge clk_i) begin
    priority if (zt[34]) begin
      ang_q <= '0;
    end else if (zt > 35'sd2147483648) begin
      ang_q <= 32'h8000_0000;
    end else begin
      ang_q <= zt[31:0];
    end
  end

  // ---------------------------------------------------------------- result
  assign h3 = {1'b0, ang_q, 1'b0} + 34'(ang_q) + (34'd1 << 17);

  always_ff @(posedge clk_i) begin
    if (vd_q[N_VDLY-1].fixed) begin
      day_hours_o  <= vd_q[N_VDLY-1].hours;
      light_case_o <= vd_q[N_VDLY-1].lcase;
    end else begin
      day_hours_o  <= h3[32:18];
      light_case_o <= dh_pkg::LC_NORMAL;
    end
  end

endmodule

// ===== verif/daylight_hours_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for daylight_hours_top: predicts hours and light case for every
// accepted transfer and compares results in order. Depends on dh_pkg.
module daylight_hours_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] latitude_i,
  input  logic [8:0]         day_of_year_i,
  input  logic               done_o,
  input  logic [14:0]        day_hours_o,
  input  logic [1:0]         light_case_o,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [14:0]         hours;
    dh_pkg::light_case_e lcase;
  } daylight_t;

  localparam longint ONE_Q30 = 64'sd1073741824;

  const longint arc_tab[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  daylight_t daylight_q[$];

  // Rotate a binary angle to Q30 cosine and sine.
  task automatic rotate_angle(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy, t;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    if (z == 0) begin
      x = ONE_Q30;
    end else begin
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arc_tab[i];
        end else begin
          x += dx; y -= dy; z += arc_tab[i];
        end
      end
    end
    case (ang[31:30])
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = x;
    s = y;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint hour_angle(input longint xi, input longint yi);
    longint x, y, z, dx, dy, t, base;
    x = xi; y = yi; z = 0; base = 0;
    if (x < 0) begin
      t = x; x = y; y = -t;
      base = ONE_Q30;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_tab[i];
      end else begin
        x -= dx; y += dy; z -= arc_tab[i];
      end
    end
    z += base;
    if (z < 0) z = 0;
    if (z > 2 * ONE_Q30) z = 2 * ONE_Q30;
    return z;
  endfunction

  task automatic predict_daylight(input logic signed [15:0] lat, input logic [8:0] doy,
                                  output daylight_t res);
    longint unsigned lmag, lt, m, cmag, dm, ysq;
    logic [31:0] lat_ang, phase, dec_ang;
    longint cy, sy, cl, sl, cd, sd, num, den, x, d, x30, d30, ang;
    lmag = (lat < 0) ? longint'(-int'(lat)) : longint'(lat);
    lt = ((lmag << 24) + 180) / 360;
    lat_ang = (lat < 0) ? 32'(-lt) : 32'(lt);
    m = (longint'(doy) + 10) % 365;
    phase = 32'(((m << 32) + 182) / 365);
    rotate_angle(phase, cy, sy);
    cmag = (cy < 0) ? -cy : cy;
    dm = (13 * cmag + 25) / 50;
    dec_ang = (cy > 0) ? 32'(-dm) : 32'(dm);
    rotate_angle(lat_ang, cl, sl);
    rotate_angle(dec_ang, cd, sd);
    num = sl * sd;
    den = cl * cd;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0) begin
      if (num > 0) res = '{dh_pkg::HOURS_FULL, dh_pkg::LC_DAY};
      else if (num < 0) res = '{dh_pkg::HOURS_NONE, dh_pkg::LC_NIGHT};
      else res = '{dh_pkg::HOURS_HALF, dh_pkg::LC_NORMAL};
    end else if (num >= den) begin
      res = '{dh_pkg::HOURS_FULL, dh_pkg::LC_DAY};
    end else if (num <= -den) begin
      res = '{dh_pkg::HOURS_NONE, dh_pkg::LC_NIGHT};
    end else begin
      x = -num;
      d = den;
      while (d < (64'sd1 << 60)) begin
        d *= 2;
        x *= 2;
      end
      x30 = x / ONE_Q30;
      d30 = d / ONE_Q30;
      ysq = longint'(d30 * d30) - longint'(x30 * x30);
      ang = hour_angle(x30, longint'(root_floor(ysq)));
      res.hours = 15'((ang * 3 + (64'sd1 << 17)) >>> 18);
      res.lcase = dh_pkg::LC_NORMAL;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    daylight_t want;
    if (!rst_ni) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (start && !busy) begin
        predict_daylight(latitude_i, day_of_year_i, want);
        daylight_q.push_back(want);
      end
      if (done_o) begin
        if (daylight_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: hours %0d case %0d", day_hours_o, light_case_o);
          fail_count <= fail_count + 1;
        end else begin
          want = daylight_q.pop_front();
          if (want.hours !== day_hours_o || want.lcase !== light_case_o) begin
            if (fail_count < 10)
              $display("mismatch: expected hours %0d case %0d, got hours %0d case %0d",
                       want.hours, want.lcase, day_hours_o, light_case_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= daylight_q.size();
    end
  end

endmodule

// ===== verif/tb_daylight_hours_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for daylight_hours_top: directed and random latitude/day
// transfers with idle bursts. Depends on dh_pkg and daylight_hours_checker.
module tb_daylight_hours_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] latitude_i = '0;
  logic [8:0]         day_of_year_i = '0;
  logic               done_o;
  logic [14:0]        day_hours_o;
  logic [1:0]         light_case_o;
  int                 fail_count;
  int                 pending_count;
  int                 sent;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  daylight_hours_top dut (.*);

  daylight_hours_checker chk (.*);

  task automatic send_item(input logic signed [15:0] lat, input logic [8:0] doy);
    start         <= 1'b1;
    latitude_i    <= lat;
    day_of_year_i <= doy;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 11)) @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] lat;
    logic [8:0] doy;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes, poles, beyond-pole wrap and out-of-range days
    send_item(16'sd0, 9'd80);
    send_item(16'sd23040, 9'd172);
    send_item(-16'sd23040, 9'd172);
    send_item(16'sd23040, 9'd355);
    send_item(-16'sd23040, 9'd1);
    send_item(16'sd23039, 9'd366);
    send_item(-16'sd23039, 9'd200);
    send_item(16'sd32767, 9'd100);
    send_item(-16'sd32768, 9'd300);
    send_item(16'sd17280, 9'd172);
    send_item(-16'sd17280, 9'd172);
    send_item(16'sd16999, 9'd355);
    send_item(16'sd12800, 9'd0);
    send_item(16'sd12800, 9'd511);
    send_item(-16'sd1, 9'd355);
    send_item(16'sd1, 9'd365);
    send_item(16'sd23041, 9'd172);
    send_item(16'sh5555, 9'h155);
    send_item(16'shAAAA, 9'h0AA);
    for (int n = 0; n < 850; n++) begin
      if (n < 700 && $urandom_range(0, 5) == 0) idle_burst();
      case ($urandom_range(0, 9))
        0: begin lat = 16'($urandom()); doy = 9'($urandom()); end
        1: begin
          lat = 16'($urandom_range(16500, 23040));
          if ($urandom_range(0, 1)) lat = -lat;
          doy = 9'($urandom_range(1, 366));
        end
        default: begin
          lat = 16'(int'($urandom_range(0, 46080)) - 23040);
          doy = 9'($urandom_range(1, 366));
        end
      endcase
      send_item(lat, doy);
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (dh_pkg::PIPE_LAT + 20) @(posedge clk_i);
    $display("drove %0d latitude/day transfers: poles, wrap beyond 90 degrees,", sent);
    $display("out-of-range days and random idle gaps");
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dh_pkg.sv
rtl/core/dh_sincos.sv
rtl/core/daylight_hours_top.sv
verif/daylight_hours_checker.sv
verif/tb_daylight_hours_top.sv
